/* hdl/srj_pkg.sv */
// Package for the short resistance judge: widths, constants, shared types
// and the window/judge functions used by the control and output stages.
// No dependencies.
`default_nettype none

package srj_pkg;

  localparam int unsigned ReadingW  = 24;
  localparam int unsigned LimitW    = 23;
  localparam int unsigned BudgetW   = 8;
  localparam int unsigned CfgIdxW   = 1;

  localparam int unsigned RetestFactor = 5;
  localparam int unsigned Limit5W      = LimitW + 3;

  localparam int unsigned RunLength = 6;
  localparam int unsigned RunCntW   = $clog2(RunLength + 1);
  localparam int unsigned SumW      = (ReadingW - 1) + $clog2(RunLength);

  // mean = (sum * MeanRecip) >> MeanShift, exact for sum < 2**SumW
  localparam int unsigned MeanShift = SumW + RunCntW;
  localparam int unsigned RecipW    = MeanShift + 1;
  localparam logic [RecipW-1:0] MeanRecip =
    RecipW'(((64'd1 << MeanShift) + 64'(RunLength) - 64'd1) / 64'(RunLength));

  localparam logic signed [ReadingW-1:0] WinLowMohm  = 24'sd10000;
  localparam logic signed [ReadingW-1:0] WinHighMohm = 24'sd50000;
  localparam int unsigned WinDivisor  = 5;
  localparam int unsigned WinInW      = 16;
  localparam int unsigned WinDivShift = 18;
  localparam int unsigned WinRecipW   = 17;
  localparam logic [WinRecipW-1:0] WinRecip =
    WinRecipW'(((32'd1 << WinDivShift) + 32'(WinDivisor) - 32'd1) / 32'(WinDivisor));

  localparam logic [LimitW-1:0]  LimitReset  = 23'd5000;
  localparam logic [BudgetW-1:0] BudgetReset = 8'd150;

  localparam logic [CfgIdxW-1:0] CfgIdxLimit  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxBudget = 1'b1;

  typedef struct packed {
    logic [LimitW-1:0]  limit;
    logic [Limit5W-1:0] limit5;
    logic [BudgetW-1:0] budget;
  } cfg_t;

  typedef struct packed {
    logic signed [ReadingW-1:0] raw;
    logic [SumW-1:0]            sum;
    logic                       averaged;
    logic                       retested;
  } emit_t;

  typedef struct packed {
    logic signed [ReadingW-1:0] value;
    logic                       averaged;
    logic                       retested;
  } res_t;

  function automatic logic in_window(logic signed [ReadingW-1:0] v);
    return (v > WinLowMohm) && (v < WinHighMohm);
  endfunction

  // floor(v/5) < limit is the same as v < 5*limit inside the window
  function automatic logic judge_pass(logic signed [ReadingW-1:0] v, cfg_t cfg);
    logic pos;
    pos = !v[ReadingW-1] && (v != '0);
    if (in_window(v)) begin
      return Limit5W'($unsigned(v)) < cfg.limit5;
    end
    return pos && (v[LimitW-1:0] < cfg.limit);
  endfunction

  function automatic logic signed [ReadingW-1:0] window_rule(logic signed [ReadingW-1:0] v);
    logic [WinInW+WinRecipW-1:0] prod;
    prod = v[WinInW-1:0] * WinRecip;
    if (in_window(v)) begin
      return signed'(ReadingW'(prod >> WinDivShift));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/short_resistance_judge.sv */
// Short resistance judge: top level with configuration registers and the
// three pipeline stages. Depends on srj_pkg, srj_ctrl, srj_mean, srj_judge.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one reading in milliohms
//   and a start mark for the first reading of a pin pair. Output channel
//   (out_valid_o/out_ready_i) carries at most one result per reading: the
//   judged value, pass, retested and averaged flags.
//   Readings that end a pair (passing quick check, completed run, or used-up
//   budget) produce a result; all others at most update the retest state.
//   A result is registered in the control, mean and judge stages in turn.
//   Throughput: one reading per cycle while in_ready_o is high; the state
//   update is a combinational compare and add, the run mean a registered
//   multiply. Stall: each stage holds its item while the receiver is not
//   ready; in_ready_o falls only when all three stages hold items. Reset:
//   clears pipeline valids and retest state; limit returns to 5000 milliohms
//   and budget to 150 readings. Config writes (cfg_we_i) take effect at the
//   next edge; the user must make them while idle, unchecked by the block.
`default_nettype none

module short_resistance_judge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srj_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [srj_pkg::LimitW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [srj_pkg::ReadingW-1:0] reading_mohm_i,
  input  logic                                start_pair_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [srj_pkg::ReadingW-1:0] result_mohm_o,
  output logic                                pass_o,
  output logic                                retested_o,
  output logic                                averaged_o
);
  import srj_pkg::*;

  cfg_t  cfg_q;
  logic  s1_valid, s2_valid, s2_ready, s3_ready;
  emit_t s1_emit;
  res_t  s2_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit  <= LimitReset;
      cfg_q.limit5 <= Limit5W'(LimitReset) * Limit5W'(RetestFactor);
      cfg_q.budget <= BudgetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxLimit: begin
          cfg_q.limit  <= cfg_wdata_i;
          cfg_q.limit5 <= Limit5W'(cfg_wdata_i) * Limit5W'(RetestFactor);
        end
        CfgIdxBudget: begin
          cfg_q.budget <= cfg_wdata_i[BudgetW-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  srj_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .reading_mohm_i (reading_mohm_i),
    .start_pair_i   (start_pair_i),
    .cfg_i          (cfg_q),
    .ready_i        (s2_ready),
    .valid_o        (s1_valid),
    .emit_o         (s1_emit)
  );

  srj_mean u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .emit_i  (s1_emit),
    .ready_i (s3_ready),
    .valid_o (s2_valid),
    .res_o   (s2_res)
  );

  srj_judge u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s2_valid),
    .ready_o       (s3_ready),
    .res_i         (s2_res),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_mohm_o (result_mohm_o),
    .pass_o        (pass_o),
    .retested_o    (retested_o),
    .averaged_o    (averaged_o)
  );

`ifndef NO_ASSERTIONS
  a_pass_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pass_o |-> !result_mohm_o[ReadingW-1] && (result_mohm_o != '0) &&
                              (result_mohm_o[LimitW-1:0] < cfg_q.limit))
    else $error("pass flagged on out-of-range result");

  a_avg_retested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && averaged_o |-> retested_o)
    else $error("averaged result without retest");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s1_valid && s2_valid)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

/* hdl/srj_ctrl.sv */
// Retest sequencer: quick check, run and budget tracking, first pipeline register.
// Depends on srj_pkg.
`default_nettype none

module srj_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [srj_pkg::ReadingW-1:0] reading_mohm_i,
  input  logic                             start_pair_i,
  input  srj_pkg::cfg_t                    cfg_i,
  input  logic                             ready_i,
  output logic                             valid_o,
  output srj_pkg::emit_t                   emit_o
);
  import srj_pkg::*;

  logic                       retest_q, retest_d;
  logic [RunCntW-1:0]         run_cnt_q, run_cnt_d;
  logic [SumW-1:0]            run_sum_q, run_sum_d;
  logic [BudgetW-1:0]         smp_cnt_q, smp_cnt_d;
  logic signed [ReadingW-1:0] last_bad_q, last_bad_d;
  logic                       valid_q, valid_d;
  emit_t                      emit_q, emit_d;
  logic                       accept, fire;
  logic [RunCntW-1:0]         cnt_n;
  logic [SumW-1:0]            sum_n;
  logic [BudgetW-1:0]         smp_n;
  logic                       good;

  assign in_ready_o = !valid_q || ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    retest_d   = retest_q;
    run_cnt_d  = run_cnt_q;
    run_sum_d  = run_sum_q;
    smp_cnt_d  = smp_cnt_q;
    last_bad_d = last_bad_q;
    fire       = 1'b0;
    emit_d     = emit_q;
    smp_n      = smp_cnt_q + 1'b1;
    good       = !reading_mohm_i[ReadingW-1] && (reading_mohm_i != '0) &&
                 (Limit5W'($unsigned(reading_mohm_i)) < cfg_i.limit5);
    sum_n      = good ? run_sum_q + SumW'(reading_mohm_i[LimitW-1:0]) : '0;
    cnt_n      = good ? run_cnt_q + 1'b1 : '0;
    if (accept) begin
      if (start_pair_i) begin
        if (judge_pass(reading_mohm_i, cfg_i)) begin
          retest_d        = 1'b0;
          fire            = 1'b1;
          emit_d.raw      = reading_mohm_i;
          emit_d.averaged = 1'b0;
          emit_d.retested = 1'b0;
        end else begin
          retest_d   = 1'b1;
          run_cnt_d  = '0;
          run_sum_d  = '0;
          smp_cnt_d  = '0;
          last_bad_d = '0;
        end
      end else if (retest_q) begin
        smp_cnt_d = smp_n;
        run_cnt_d = cnt_n;
        run_sum_d = sum_n;
        if (!good) begin
          last_bad_d = reading_mohm_i;
        end
        if (cnt_n == RunCntW'(RunLength)) begin
          retest_d        = 1'b0;
          run_cnt_d       = '0;
          run_sum_d       = '0;
          fire            = 1'b1;
          emit_d.sum      = sum_n;
          emit_d.averaged = 1'b1;
          emit_d.retested = 1'b1;
        end else if (smp_n == cfg_i.budget) begin
          retest_d        = 1'b0;
          run_cnt_d       = '0;
          run_sum_d       = '0;
          fire            = 1'b1;
          emit_d.raw      = good ? last_bad_q : reading_mohm_i;
          emit_d.averaged = 1'b0;
          emit_d.retested = 1'b1;
        end
      end
    end
    valid_d = fire ? 1'b1 : (ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retest_q   <= 1'b0;
      run_cnt_q  <= '0;
      run_sum_q  <= '0;
      smp_cnt_q  <= '0;
      last_bad_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      retest_q   <= retest_d;
      run_cnt_q  <= run_cnt_d;
      run_sum_q  <= run_sum_d;
      smp_cnt_q  <= smp_cnt_d;
      last_bad_q <= last_bad_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      emit_q <= emit_d;
    end
  end

  assign valid_o = valid_q;
  assign emit_o  = emit_q;

endmodule

`default_nettype wire

/* hdl/srj_mean.sv */
// Second stage: run mean by reciprocal multiply, selects the value to judge.
// Depends on srj_pkg.
`default_nettype none

module srj_mean (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  srj_pkg::emit_t emit_i,
  input  logic           ready_i,
  output logic           valid_o,
  output srj_pkg::res_t  res_o
);
  import srj_pkg::*;

  logic                     valid_q;
  res_t                     res_q, res_d;
  logic                     load;
  logic [SumW+RecipW-1:0]   prod;
  logic [LimitW-1:0]        mean;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    prod           = emit_i.sum * MeanRecip;
    mean           = prod[MeanShift +: LimitW];
    res_d.value    = emit_i.averaged ? signed'(ReadingW'(mean)) : emit_i.raw;
    res_d.averaged = emit_i.averaged;
    res_d.retested = emit_i.retested;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* hdl/srj_judge.sv */
// Output stage: window rule, pass judgment and the result register.
// Depends on srj_pkg.
`default_nettype none

module srj_judge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  srj_pkg::res_t                       res_i,
  input  srj_pkg::cfg_t                       cfg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [srj_pkg::ReadingW-1:0] result_mohm_o,
  output logic                                pass_o,
  output logic                                retested_o,
  output logic                                averaged_o
);
  import srj_pkg::*;

  logic                       valid_q;
  logic signed [ReadingW-1:0] result_q;
  logic                       pass_q, retested_q, averaged_q;
  logic                       load;

  assign ready_o = !valid_q || out_ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q   <= window_rule(res_i.value);
      pass_q     <= judge_pass(res_i.value, cfg_i);
      retested_q <= res_i.retested;
      averaged_q <= res_i.averaged;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_mohm_o = result_q;
  assign pass_o        = pass_q;
  assign retested_o    = retested_q;
  assign averaged_o    = averaged_q;

endmodule

`default_nettype wire

/* verif/tb_short_resistance_judge.sv */
// Self-checking testbench for short_resistance_judge: directed and random
// pin-pair reading streams checked against an in-bench judge predictor.
// Depends on srj_pkg and the short_resistance_judge RTL.
module tb_short_resistance_judge;
  timeunit 1ns;
  timeprecision 1ps;
  import srj_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;
  localparam int MaxReading    = 8388607;
  localparam int MinReading    = -8388608;

  typedef enum logic {PH_IDLE, PH_RETEST} pair_phase_e;

  typedef struct {
    logic signed [ReadingW-1:0] value;
    logic                       pass;
    logic                       retested;
    logic                       averaged;
  } verdict_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx_i      = CfgIdxLimit;
  logic [LimitW-1:0]          cfg_wdata_i    = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic signed [ReadingW-1:0] reading_mohm_i = '0;
  logic                       start_pair_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic signed [ReadingW-1:0] result_mohm_o;
  logic                       pass_o;
  logic                       retested_o;
  logic                       averaged_o;

  short_resistance_judge dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .reading_mohm_i (reading_mohm_i),
    .start_pair_i   (start_pair_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_mohm_o  (result_mohm_o),
    .pass_o         (pass_o),
    .retested_o     (retested_o),
    .averaged_o     (averaged_o)
  );

  // judge predictor state
  logic [LimitW-1:0]          limit_cfg        = LimitReset;
  logic [BudgetW-1:0]         budget_cfg       = BudgetReset;
  pair_phase_e                pair_phase       = PH_IDLE;
  int                         run_len          = 0;
  logic [26:0]                run_total        = '0;
  logic [7:0]                 retest_samples   = '0;
  logic signed [ReadingW-1:0] last_bad_reading = '0;
  verdict_t                   expected_verdicts[$];

  int judged_items     = 0;
  int fail_count       = 0;
  int quick_results    = 0;
  int mean_results     = 0;
  int fallback_results = 0;
  int send_idle_pct    = 0;
  int stall_pct        = 0;
  int hold_request     = 0;
  int hold_left        = 0;
  int idle_cycles      = 0;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  function automatic int apply_window(int v);
    if (v > int'(WinLowMohm) && v < int'(WinHighMohm)) return v / int'(WinDivisor);
    return v;
  endfunction

  function automatic bit below_limit(int v);
    return v > 0 && longint'(v) < longint'(limit_cfg);
  endfunction

  function automatic void post_verdict(int raw, bit retested, bit averaged);
    verdict_t v;
    int       w;
    w          = apply_window(raw);
    v.value    = ReadingW'(w);
    v.pass     = below_limit(w);
    v.retested = retested;
    v.averaged = averaged;
    expected_verdicts.push_back(v);
  endfunction

  // Returns 1 when the reading is consumed, 0 when the block ignores it.
  function automatic bit judge_reading(logic signed [ReadingW-1:0] reading, logic start);
    int r;
    r = reading;
    if (start) begin
      if (below_limit(apply_window(r))) begin
        pair_phase = PH_IDLE;
        post_verdict(r, 1'b0, 1'b0);
      end else begin
        pair_phase       = PH_RETEST;
        run_len          = 0;
        run_total        = '0;
        retest_samples   = '0;
        last_bad_reading = '0;
      end
      return 1'b1;
    end
    if (pair_phase != PH_RETEST) return 1'b0;
    retest_samples = retest_samples + 8'd1;
    if (r > 0 && longint'(r) < longint'(limit_cfg) * longint'(RetestFactor)) begin
      run_total = run_total + 27'(r);
      run_len++;
    end else begin
      run_len          = 0;
      run_total        = '0;
      last_bad_reading = reading;
    end
    if (run_len >= RunLength) begin
      pair_phase = PH_IDLE;
      post_verdict(int'(run_total / RunLength), 1'b1, 1'b1);
      run_len   = 0;
      run_total = '0;
    end else if (retest_samples == budget_cfg) begin
      pair_phase = PH_IDLE;
      post_verdict(last_bad_reading, 1'b1, 1'b0);
      run_len   = 0;
      run_total = '0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [ReadingW-1:0] good_retest_reading();
    longint top;
    top = longint'(limit_cfg) * 5 - 1;
    if (top > MaxReading) top = MaxReading;
    if (top < 1) return ReadingW'(1);
    case ($urandom_range(9))
      0:       return ReadingW'(1);
      1:       return ReadingW'(top);
      default: return ReadingW'($urandom_range(int'(top), 1));
    endcase
  endfunction

  function automatic logic signed [ReadingW-1:0] bad_retest_reading();
    longint floor5;
    floor5 = longint'(limit_cfg) * 5;
    case ($urandom_range(3))
      0: return '0;
      1: return ReadingW'(-int'($urandom_range(8388608, 1)));
      2: begin
        if (floor5 <= MaxReading) return ReadingW'($urandom_range(MaxReading, int'(floor5)));
        return ReadingW'(-1);
      end
      default: return ReadingW'($urandom);
    endcase
  endfunction

  function automatic logic signed [ReadingW-1:0] first_reading(bit want_pass);
    if (want_pass && limit_cfg > 1) return ReadingW'($urandom_range(int'(limit_cfg) - 1, 1));
    case ($urandom_range(2))
      0:       return ReadingW'(-int'($urandom_range(8388608, 0)));
      1:       return ReadingW'($urandom_range(MaxReading, int'(limit_cfg)));
      default: return ReadingW'($urandom);
    endcase
  endfunction

  task automatic send_reading(input logic signed [ReadingW-1:0] reading, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    reading_mohm_i <= reading;
    start_pair_i   <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (judge_reading(reading, start)) judged_items++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxLimit) limit_cfg = data;
    else budget_cfg = data[BudgetW-1:0];
  endtask

  task automatic set_traffic(input int send_pct, input int stall);
    send_idle_pct = send_pct;
    stall_pct     = stall;
  endtask

  task automatic drive_pairs(input int item_goal);
    int goal;
    int bad_pct;
    goal = judged_items + item_goal;
    while (judged_items < goal) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(4, 1)) send_reading(ReadingW'($urandom), 1'($urandom));
      end else begin
        send_reading(first_reading($urandom_range(3) == 0), 1'b1);
        bad_pct = ($urandom_range(1) == 0) ? 6 : 55;
        while (pair_phase == PH_RETEST && judged_items < goal) begin
          if ($urandom_range(99) < 3) send_reading(ReadingW'($urandom), 1'($urandom));
          else if ($urandom_range(99) < bad_pct) send_reading(bad_retest_reading(), 1'b0);
          else send_reading(good_retest_reading(), 1'b0);
        end
      end
    end
    while (pair_phase == PH_RETEST) send_reading(good_retest_reading(), 1'b0);
  endtask

  task automatic test_quick_checks();
    set_traffic(0, 0);
    send_reading(24'sd1, 1'b1);
    send_reading(24'sd4999, 1'b1);
    send_reading(24'sd24999, 1'b1);
    send_reading(24'sd25000, 1'b1);
    send_reading(24'sd10000, 1'b1);
    send_reading(24'sd50000, 1'b1);
    send_reading(ReadingW'(MinReading), 1'b1);
    send_reading(24'sd0, 1'b1);
    send_reading(24'sd8388607, 1'b1);
    send_reading(24'sd1, 1'b0);
    send_reading(24'sd24999, 1'b0);
    send_reading(24'sd10001, 1'b0);
    send_reading(24'sd12000, 1'b0);
    send_reading(24'sd3, 1'b0);
    send_reading(24'sd20000, 1'b0);
    send_reading(24'sd777, 1'b0);
  endtask

  task automatic test_fallback();
    write_reg(CfgIdxBudget, 23'd4);
    send_reading(24'sd0, 1'b1);
    send_reading(24'sd100, 1'b0);
    send_reading(-24'sd5, 1'b0);
    send_reading(24'sd25000, 1'b0);
    send_reading(24'sd200, 1'b0);
    write_reg(CfgIdxBudget, 23'd3);
    send_reading(-24'sd1, 1'b1);
    send_reading(24'sd1, 1'b0);
    send_reading(24'sd2, 1'b0);
    send_reading(24'sd3, 1'b0);
    write_reg(CfgIdxBudget, 23'd6);
    send_reading(24'sd5000, 1'b1);
    send_reading(24'sd24999, 1'b0);
    repeat (5) send_reading(good_retest_reading(), 1'b0);
    write_reg(CfgIdxBudget, LimitW'(BudgetReset));
  endtask

  task automatic test_limit_extremes();
    write_reg(CfgIdxLimit, '1);
    write_reg(CfgIdxBudget, 23'd255);
    send_reading(24'sd8388606, 1'b1);
    send_reading(24'sd49999, 1'b1);
    send_reading(-24'sd1, 1'b1);
    repeat (6) send_reading(24'sd8388607, 1'b0);
    write_reg(CfgIdxLimit, '0);
    write_reg(CfgIdxBudget, 23'd3);
    send_reading(24'sd1, 1'b1);
    send_reading(24'sd1, 1'b0);
    send_reading(24'sd2, 1'b0);
    send_reading(24'sd100, 1'b0);
    write_reg(CfgIdxLimit, 23'd1);
    send_reading(24'sd1, 1'b1);
    send_reading(24'sd4, 1'b0);
    send_reading(-24'sd1, 1'b0);
    send_reading(24'sd4, 1'b0);
    write_reg(CfgIdxLimit, LimitReset);
    write_reg(CfgIdxBudget, LimitW'(BudgetReset));
  endtask

  // budget 0 wraps the sample counter: the verdict comes on reading 256
  task automatic test_budget_wrap();
    write_reg(CfgIdxBudget, '0);
    send_reading(24'sd0, 1'b1);
    repeat (256) send_reading(ReadingW'(-int'($urandom_range(8388608, 0))), 1'b0);
    write_reg(CfgIdxBudget, LimitW'(BudgetReset));
  endtask

  task automatic test_backpressure();
    set_traffic(0, 0);
    hold_request = HoldCycles;
    repeat (40) send_reading(first_reading(1'b1), 1'b1);
  endtask

  task automatic test_random_traffic();
    int          send_mix[4]   = '{0, 69, 0, 34};
    int          stall_mix[4]  = '{0, 0, 69, 34};
    int unsigned limit_set[6]  = '{5000, 1, 8388607, 2000, 12000, 0};
    int unsigned budget_set[6] = '{150, 1, 255, 20, 8, 0};
    int          pick;
    for (int m = 0; m < 4; m++) begin
      set_traffic(send_mix[m], stall_mix[m]);
      for (int k = 0; k < 3; k++) begin
        pick = (m * 3 + k) % 6;
        if (pick == 5) begin
          write_reg(CfgIdxLimit, LimitW'($urandom_range(MaxReading, 1)));
          write_reg(CfgIdxBudget, LimitW'($urandom_range(255, 1)));
        end else begin
          write_reg(CfgIdxLimit, LimitW'(limit_set[pick]));
          write_reg(CfgIdxBudget, LimitW'(budget_set[pick]));
        end
        drive_pairs(120);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no verdict pending: result_mohm %0d", result_mohm_o);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (result_mohm_o !== want.value) begin
          $error("result_mohm: expected %0d, got %0d", want.value, result_mohm_o);
          fail_count++;
        end
        if (pass_o !== want.pass) begin
          $error("pass: expected %0b, got %0b", want.pass, pass_o);
          fail_count++;
        end
        if (retested_o !== want.retested) begin
          $error("retested: expected %0b, got %0b", want.retested, retested_o);
          fail_count++;
        end
        if (averaged_o !== want.averaged) begin
          $error("averaged: expected %0b, got %0b", want.averaged, averaged_o);
          fail_count++;
        end
        if (!want.retested) quick_results++;
        else if (want.averaged) mean_results++;
        else fallback_results++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("** short_resistance_judge: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_quick_checks();
    test_fallback();
    test_limit_extremes();
    test_budget_wrap();
    test_backpressure();
    test_random_traffic();
    settle();
    $display("Judged %0d readings under four idle/stall mixes and a long output hold.",
             judged_items);
    $display("Verdicts: %0d quick pass, %0d run mean, %0d fallback; limits 0..max, budgets 0..255.",
             quick_results, mean_results, fallback_results);
    if (fail_count == 0) begin
      $display("** short_resistance_judge: PASSED **");
    end else begin
      $display("** short_resistance_judge: FAILED **");
    end
    $finish;
  end

endmodule
